@@ rtl/scc_pkg.sv @@
// Shared constants and types for the strip cluster centroid block.
package scc_pkg;

  // Cluster limits and fixed-point format.
  localparam int MAX_CLUSTER_STRIPS = 64;
  localparam int FRAC_BITS          = 8;
  localparam int STRIP_COUNT        = 384;

  // Field and datapath widths.
  localparam int START_W = 9;
  localparam int AMP_W   = 13;
  localparam int MAG_W   = 13;
  localparam int POS_W   = 9;
  localparam int PROD_W  = MAG_W + POS_W;
  localparam int CSUM_W  = 19;
  localparam int WSUM_W  = 28;
  localparam int CENT_W  = 17;
  localparam int IDX_W   = $clog2(MAX_CLUSTER_STRIPS + 1);

  // Divider sizing: one quotient bit per step over the shifted dividend.
  localparam int DIVD_W = WSUM_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DIVD_W);

  // Queue between the accumulator and the divider.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Final sums of one closed cluster.
  typedef struct packed {
    logic [WSUM_W-1:0] weighted;
    logic [CSUM_W-1:0] charge;
  } sums_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

@@ rtl/strip_cluster_centroid.sv @@
// Top level of the strip cluster centroid block.
//
//   Channel  Handshake                   Payload
//   strip    strip_valid / strip_stall   start_strip, amplitude, last_strip
//   result   result_valid / result_stall centroid, no_charge, out_of_range
//
// Strips are taken one per cycle while the strip side does not stall; a product stage
// and a saturating adder form the sums. A closed cluster waits in a two-entry queue
// for the divider, which yields one quotient bit a cycle.
// The divider takes the next cluster from the queue only once the last result is registered.
// Reset is synchronous and empties the pipeline, queue and result register.
// The strip side stalls only when a closing strip finds the queue full.
module strip_cluster_centroid (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            strip_valid,
  output logic                            strip_stall,
  input  logic [scc_pkg::START_W-1:0]     start_strip,
  input  logic signed [scc_pkg::AMP_W-1:0] amplitude,
  input  logic                            last_strip,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [scc_pkg::CENT_W-1:0]      centroid,
  output logic                            no_charge,
  output logic                            out_of_range
);
  import scc_pkg::*;

  logic          push;
  logic          pop;
  sums_t         push_sums;
  sums_t         head;
  queue_status_t q_status;

  // Strip intake and accumulation.
  scc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .strip_valid (strip_valid),
    .strip_stall (strip_stall),
    .start_strip (start_strip),
    .amplitude   (amplitude),
    .last_strip  (last_strip),
    .q_status    (q_status),
    .push        (push),
    .push_sums   (push_sums)
  );

  // Decoupling queue.
  scc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_sums (push_sums),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Centroid division and result register.
  scc_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .centroid     (centroid),
    .no_charge    (no_charge),
    .out_of_range (out_of_range)
  );

endmodule

@@ rtl/scc_front.sv @@
// Front end: takes strips, tracks position and accumulates the cluster sums.
module scc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         strip_valid,
  output logic                         strip_stall,
  input  logic [scc_pkg::START_W-1:0]  start_strip,
  input  logic signed [scc_pkg::AMP_W-1:0] amplitude,
  input  logic                         last_strip,
  input  scc_pkg::queue_status_t       q_status,
  output logic                         push,
  output scc_pkg::sums_t               push_sums
);
  import scc_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Cluster tracking.
  logic             in_cluster;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;

  // Product stage.
  logic              s1_valid;
  logic              s1_first;
  logic              s1_last;
  logic [MAG_W-1:0]  s1_mag;
  logic [PROD_W-1:0] s1_prod;

  // Running sums.
  logic [CSUM_W-1:0] charge_sum;
  logic [WSUM_W-1:0] weighted_sum;

  logic             accept;
  logic             s1_advance;
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] pos_cur;
  logic [IDX_W-1:0] idx_cur;
  logic             take;

  logic [CSUM_W-1:0] charge_base;
  logic [WSUM_W-1:0] weighted_base;
  logic [CSUM_W:0]   charge_add;
  logic [WSUM_W:0]   weighted_add;
  logic [CSUM_W-1:0] charge_sum_next;
  logic [WSUM_W-1:0] weighted_sum_next;

  // Handshake: the product stage drains unless a closing strip meets a full queue.
  assign s1_advance  = s1_valid && (!s1_last || !q_status.full);
  assign strip_stall = s1_valid && !s1_advance;
  assign accept      = strip_valid && !strip_stall;

  // Magnitude of the amplitude and the position of this strip.
  assign mag     = amplitude[AMP_W-1] ? MAG_W'(-amplitude) : MAG_W'(amplitude);
  assign pos_cur = in_cluster ? pos : POS_W'(start_strip);
  assign idx_cur = in_cluster ? idx : '0;
  assign take    = idx_cur < IDX_W'(MAX_CLUSTER_STRIPS);

  // Accumulation with saturation; a new cluster starts from zero.
  assign charge_base   = s1_first ? '0 : charge_sum;
  assign weighted_base = s1_first ? '0 : weighted_sum;
  assign charge_add    = {1'b0, charge_base} + (CSUM_W + 1)'(s1_mag);
  assign weighted_add  = {1'b0, weighted_base} + (WSUM_W + 1)'(s1_prod);
  assign charge_sum_next   = charge_add[CSUM_W] ? '1 : charge_add[CSUM_W-1:0];
  assign weighted_sum_next = weighted_add[WSUM_W] ? '1 : weighted_add[WSUM_W-1:0];

  assign push               = s1_advance && s1_last;
  assign push_sums.weighted = weighted_sum_next;
  assign push_sums.charge   = charge_sum_next;

  // Position tracking and the product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cluster <= 1'b0;
      pos        <= '0;
      idx        <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        in_cluster <= !last_strip;
        s1_valid   <= 1'b1;
        pos        <= (take && pos_cur != POS_MAX) ? pos_cur + 1'b1 : pos_cur;
        idx        <= take ? idx_cur + 1'b1 : idx_cur;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Payload of the product stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first <= !in_cluster;
      s1_last  <= last_strip;
      s1_mag   <= take ? mag : '0;
      s1_prod  <= take ? PROD_W'(mag) * PROD_W'(pos_cur) : '0;
    end
  end

  // Running sums follow each strip that leaves the product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      charge_sum   <= '0;
      weighted_sum <= '0;
    end else if (s1_advance) begin
      charge_sum   <= charge_sum_next;
      weighted_sum <= weighted_sum_next;
    end
  end

  // A stall is only ever caused by a closing strip waiting for queue space.
  assert property (@(posedge clk) disable iff (rst)
    strip_stall |-> (s1_valid && s1_last && q_status.full))
    else $error("front stalled without a blocked closing strip");

endmodule

@@ rtl/scc_queue.sv @@
// Short queue of closed-cluster sums between the front end and the divider.
module scc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  scc_pkg::sums_t         push_sums,
  input  logic                   pop,
  output scc_pkg::sums_t         head,
  output scc_pkg::queue_status_t status
);
  import scc_pkg::*;

  sums_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full      = count == QCNT_W'(QUEUE_DEPTH);
  assign status.not_empty = count != '0;
  assign head             = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_sums;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !status.full)
    else $error("push into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> status.not_empty)
    else $error("pop from an empty queue");

endmodule

@@ rtl/scc_divider.sv @@
// Back end: restoring divider that forms the centroid and holds the result.
module scc_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  scc_pkg::sums_t              head,
  input  scc_pkg::queue_status_t      q_status,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [scc_pkg::CENT_W-1:0]  centroid,
  output logic                        no_charge,
  output logic                        out_of_range
);
  import scc_pkg::*;

  localparam logic [DIVD_W-1:0] CENT_MAX   = DIVD_W'({CENT_W{1'b1}});
  localparam logic [DIVD_W-1:0] CENT_LIMIT = DIVD_W'(STRIP_COUNT) << FRAC_BITS;

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [CSUM_W-1:0] divisor;
  logic [CSUM_W-1:0] rem;
  logic [DIVD_W-1:0] quot;
  logic              nc;

  logic [CSUM_W:0]   trial;
  logic [CSUM_W+1:0] diff;
  logic              ge;
  logic              out_free;

  // One quotient bit per step.
  assign trial    = {rem, quot[DIVD_W-1]};
  assign diff     = {1'b0, trial} - (CSUM_W + 2)'(divisor);
  assign ge       = !diff[CSUM_W+1];
  assign out_free = !result_valid || !result_stall;
  assign pop      = (state == IDLE) && q_status.not_empty;

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      // A finished division refills the result register as it empties.
      if (state == FINISH && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (q_status.not_empty) begin
            divisor <= head.charge;
            nc      <= head.charge == '0;
            rem     <= '0;
            cnt     <= CNT_W'(DIVD_W - 1);
            if (head.charge == '0) begin
              quot  <= '0;
              state <= FINISH;
            end else begin
              quot  <= DIVD_W'(head.weighted) << FRAC_BITS;
              state <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          rem  <= ge ? diff[CSUM_W-1:0] : trial[CSUM_W-1:0];
          quot <= {quot[DIVD_W-2:0], ge};
          if (cnt == '0) begin
            state <= FINISH;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        FINISH: begin
          if (out_free) begin
            centroid     <= (quot > CENT_MAX) ? '1 : quot[CENT_W-1:0];
            no_charge    <= nc;
            out_of_range <= quot >= CENT_LIMIT;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == DIVIDE) |-> (rem < divisor))
    else $error("partial remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && no_charge) |-> (centroid == '0 && !out_of_range))
    else $error("empty cluster reported with a centroid");

endmodule

@@ sim/centroid_checker.sv @@
// Checker that predicts and compares the centroid results of the strip cluster block.
`timescale 1ns / 100ps

module centroid_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              strip_valid,
  input  logic                              strip_stall,
  input  logic [scc_pkg::START_W-1:0]       start_strip,
  input  logic signed [scc_pkg::AMP_W-1:0]  amplitude,
  input  logic                              last_strip,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic [scc_pkg::CENT_W-1:0]        centroid,
  input  logic                              no_charge,
  input  logic                              out_of_range,
  output int                                fail_total,
  output int                                results_awaited
);
  import scc_pkg::*;

  // One expected result of a closed cluster.
  typedef struct packed {
    logic [CENT_W-1:0] centroid;
    logic              no_charge;
    logic              out_of_range;
  } centroid_result_t;

  localparam longint unsigned CENTROID_CEIL = (64'd1 << CENT_W) - 1;
  localparam longint unsigned RANGE_LIMIT   = 64'(STRIP_COUNT) << FRAC_BITS;

  // Running state of the cluster being collected.
  logic [CSUM_W-1:0] charge_acc;
  logic [WSUM_W-1:0] weighted_acc;
  logic [POS_W-1:0]  next_position;
  int                strips_taken;
  bit                in_cluster;

  centroid_result_t pending_centroids[$];

  // Takes one strip request and queues the centroid when it closes the cluster.
  function automatic void take_strip(input logic [START_W-1:0] first_strip,
                                     input logic signed [AMP_W-1:0] amp,
                                     input logic closes);
    logic [MAG_W-1:0]  mag;
    logic [CSUM_W:0]   charge_next;
    logic [WSUM_W:0]   weighted_next;
    longint unsigned   quotient;
    centroid_result_t  res;
    mag = amp[AMP_W-1] ? MAG_W'(~amp + 1'b1) : MAG_W'(amp);
    // The first strip of a cluster starts fresh sums at its start position.
    if (!in_cluster) begin
      charge_acc    = '0;
      weighted_acc  = '0;
      strips_taken  = 0;
      next_position = first_strip;
      in_cluster    = 1'b1;
    end
    // Strips past the cluster length limit neither add charge nor move on.
    if (strips_taken < MAX_CLUSTER_STRIPS) begin
      if (mag != '0) begin
        charge_next   = charge_acc + mag;
        weighted_next = weighted_acc + mag * next_position;
        charge_acc    = charge_next[CSUM_W] ? '1 : charge_next[CSUM_W-1:0];
        weighted_acc  = weighted_next[WSUM_W] ? '1 : weighted_next[WSUM_W-1:0];
      end
      strips_taken++;
      if (next_position != '1) begin
        next_position++;
      end
    end
    if (!closes) begin
      return;
    end
    // Centre of gravity, truncated; range is judged before the ceiling applies.
    if (charge_acc == '0) begin
      res.centroid     = '0;
      res.no_charge    = 1'b1;
      res.out_of_range = 1'b0;
    end else begin
      quotient         = (64'(weighted_acc) << FRAC_BITS) / 64'(charge_acc);
      res.centroid     = (quotient > CENTROID_CEIL) ? '1 : quotient[CENT_W-1:0];
      res.no_charge    = 1'b0;
      res.out_of_range = (quotient >= RANGE_LIMIT);
    end
    pending_centroids.push_back(res);
    in_cluster = 1'b0;
  endfunction

  // Results are compared before the strip of the same edge is predicted.
  always @(posedge clk) begin
    centroid_result_t want;
    if (rst) begin
      in_cluster   = 1'b0;
      charge_acc   = '0;
      weighted_acc = '0;
      next_position = '0;
      strips_taken = 0;
      pending_centroids.delete();
      fail_total   = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_centroids.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("unexpected result: centroid=%0d no_charge=%0b out_of_range=%0b",
                     centroid, no_charge, out_of_range);
          end
        end else begin
          want = pending_centroids.pop_front();
          if (want.centroid !== centroid || want.no_charge !== no_charge ||
              want.out_of_range !== out_of_range) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("result mismatch: expected centroid=%0d no_charge=%0b out_of_range=%0b",
                       want.centroid, want.no_charge, want.out_of_range);
              $display("                 actual   centroid=%0d no_charge=%0b out_of_range=%0b",
                       centroid, no_charge, out_of_range);
            end
          end
        end
      end
      if (strip_valid && !strip_stall) begin
        take_strip(start_strip, amplitude, last_strip);
      end
    end
    results_awaited = pending_centroids.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the strip cluster centroid testbench: clock, reset, strip stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import scc_pkg::*;

  localparam int RANDOM_STRIPS = 1080;
  localparam int STUCK_LIMIT   = 4000;
  localparam int CALM_FROM     = 600;
  localparam int CALM_TO       = 850;
  localparam int HOLD_AFTER    = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam logic signed [AMP_W-1:0] AMP_MOST_NEG = {1'b1, {(AMP_W-1){1'b0}}};
  localparam logic signed [AMP_W-1:0] AMP_MOST_POS = {1'b0, {(AMP_W-1){1'b1}}};

  logic                    clk;
  logic                    rst;
  logic                    strip_valid;
  logic                    strip_stall;
  logic [START_W-1:0]      start_strip;
  logic signed [AMP_W-1:0] amplitude;
  logic                    last_strip;
  logic                    result_valid;
  logic                    result_stall;
  logic [CENT_W-1:0]       centroid;
  logic                    no_charge;
  logic                    out_of_range;
  int                      fail_total;
  int                      results_awaited;
  int                      strips_sent;

  strip_cluster_centroid i_dut (
    .clk          (clk),
    .rst          (rst),
    .strip_valid  (strip_valid),
    .strip_stall  (strip_stall),
    .start_strip  (start_strip),
    .amplitude    (amplitude),
    .last_strip   (last_strip),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .centroid     (centroid),
    .no_charge    (no_charge),
    .out_of_range (out_of_range)
  );

  centroid_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .strip_valid     (strip_valid),
    .strip_stall     (strip_stall),
    .start_strip     (start_strip),
    .amplitude       (amplitude),
    .last_strip      (last_strip),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .centroid        (centroid),
    .no_charge       (no_charge),
    .out_of_range    (out_of_range),
    .fail_total      (fail_total),
    .results_awaited (results_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one strip request from a falling edge and returns at the falling edge after
  // it is taken. Random gaps are left out during the calm stretch.
  task automatic send_strip(input logic [START_W-1:0] first_strip,
                            input logic signed [AMP_W-1:0] amp,
                            input logic closes);
    while (!(strips_sent >= CALM_FROM && strips_sent < CALM_TO) &&
           $urandom_range(99) < 23) begin
      strip_valid = 1'b0;
      @(negedge clk);
    end
    strip_valid = 1'b1;
    start_strip = first_strip;
    amplitude   = amp;
    last_strip  = closes;
    do begin
      @(posedge clk);
    end while (strip_stall);
    strips_sent++;
    @(negedge clk);
  endtask

  // Result side: one long hold-off once traffic is under way, a calm stretch, else
  // random stalls.
  initial begin
    int  hold_left;
    bit  held;
    hold_left    = 0;
    held         = 1'b0;
    result_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!held && strips_sent >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else if (strips_sent >= CALM_FROM && strips_sent < CALM_TO) begin
        result_stall = 1'b0;
      end else begin
        result_stall = ($urandom_range(99) < 23);
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((strip_valid && !strip_stall) || (result_valid && !result_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // Reset, directed clusters, random clusters, then drain and verdict.
  initial begin
    int                      sent_random;
    int                      cluster_len;
    int                      pick;
    bit                      quiet;
    logic [START_W-1:0]      first_strip;
    logic signed [AMP_W-1:0] amp;
    rst         = 1'b1;
    strip_valid = 1'b0;
    start_strip = '0;
    amplitude   = '0;
    last_strip  = 1'b0;
    strips_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single-strip clusters at both amplitude extremes and with no charge.
    send_strip(9'd383, AMP_MOST_POS, 1'b1);
    send_strip(9'd0, AMP_MOST_NEG, 1'b1);
    send_strip(9'd200, '0, 1'b1);
    // A cluster of zero strips only, and one whose charge comes at the end.
    send_strip(9'd17, '0, 1'b0);
    send_strip(9'd0, '0, 1'b0);
    send_strip(9'd0, '0, 1'b1);
    send_strip(9'd50, '0, 1'b0);
    send_strip(9'd0, '0, 1'b0);
    send_strip(9'd0, -13'sd5, 1'b1);
    // Charge beyond the last strip gives an out-of-range centroid.
    send_strip(9'd383, -13'sd1, 1'b0);
    send_strip(9'd0, AMP_MOST_POS, 1'b0);
    send_strip(9'd0, 13'sd1, 1'b1);
    // Position runs into its ceiling and stays there.
    for (int k = 0; k < 8; k++) begin
      send_strip(9'd505, 13'sd1000, k == 7);
    end
    send_strip(9'd100, 13'sd37, 1'b0);
    send_strip(9'd0, -13'sd37, 1'b1);

    // Random clusters: mostly short, some past the strip limit, a few without charge.
    sent_random = 0;
    while (sent_random < RANDOM_STRIPS) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        cluster_len = $urandom_range(80, 60);
      end else if (pick < 4) begin
        cluster_len = 1;
      end else begin
        cluster_len = $urandom_range(12, 2);
      end
      quiet = ($urandom_range(19) == 0);
      first_strip = ($urandom_range(9) == 0) ? START_W'($urandom_range(511, 384))
                                              : START_W'($urandom_range(383, 0));
      for (int k = 0; k < cluster_len; k++) begin
        pick = $urandom_range(99);
        if (quiet || pick < 15) begin
          amp = '0;
        end else if (pick < 25) begin
          case ($urandom_range(3))
            0: amp = AMP_MOST_NEG;
            1: amp = AMP_MOST_POS;
            2: amp = -13'sd1;
            default: amp = 13'sd1;
          endcase
        end else begin
          amp = AMP_W'($urandom);
        end
        send_strip((k == 0) ? first_strip : START_W'($urandom), amp, k == cluster_len - 1);
        sent_random++;
      end
    end
    strip_valid = 1'b0;

    // Wait for every outstanding centroid, then for any stray result.
    while (results_awaited != 0) begin
      @(negedge clk);
    end
    repeat (60) @(posedge clk);
    if (fail_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ strip_cluster_centroid.f @@
rtl/scc_pkg.sv
rtl/scc_front.sv
rtl/scc_queue.sv
rtl/scc_divider.sv
rtl/strip_cluster_centroid.sv
sim/centroid_checker.sv
sim/tb_top.sv
